// File: hw/rtl/tsp_pkg.sv
// Shared constants, types and a helper function of the terrain split priority core.
`default_nettype none
package tsp_pkg;

	localparam int unsigned COORD_W    = 32;
	localparam int unsigned WEDGIE_W   = 31;
	localparam int unsigned HALF_W     = 32;
	localparam int unsigned CFG_DATA_W = 64;
	localparam int unsigned REG_ADDR_W = 3;

	typedef logic [REG_ADDR_W-1:0] reg_addr_t;

	localparam reg_addr_t REG_MAT_E0_E1   = 3'd0;
	localparam reg_addr_t REG_MAT_E2_E4   = 3'd1;
	localparam reg_addr_t REG_MAT_E5_E6   = 3'd2;
	localparam reg_addr_t REG_MAT_E8_E9   = 3'd3;
	localparam reg_addr_t REG_MAT_E10_E12 = 3'd4;
	localparam reg_addr_t REG_MAT_E13_E14 = 3'd5;

	// Clamps a wide signed value to the signed range of w bits.
	function automatic logic [31:0] clamp_sat(input logic signed [63:0] x, input int unsigned w);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (w - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (x > hi) begin
			return hi[31:0];
		end else if (x < lo) begin
			return lo[31:0];
		end
		return x[31:0];
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/tsp_xform.sv
// Two-stage modelview transform of one vertex into clamped p, q and r.
`default_nettype none
module tsp_xform #(
	parameter int unsigned VALUE_WIDTH = 32,
	parameter int unsigned FRAC_BITS   = 16
) (
	input  wire logic                          clk,
	input  wire logic signed [VALUE_WIDTH-1:0] coef [3][4],
	input  wire logic signed [VALUE_WIDTH-1:0] crd  [3],
	output logic signed [VALUE_WIDTH-1:0]      pqr  [3]
);

	localparam int unsigned W = VALUE_WIDTH;
	localparam int unsigned F = FRAC_BITS;

	logic signed [2*W-1:0] prod_s1  [3][3];
	logic signed [W-1:0]   trans_s1 [3];
	logic signed [63:0]    acc      [3];
	logic [31:0]           cl       [3];

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				prod_s1[r][c] <= coef[r][c] * crd[c];
			end
			trans_s1[r] <= coef[r][3];
		end
	end

	// Each product is floored to the fixed-point grid before the sum.
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			acc[r] = (64'(prod_s1[r][0]) >>> F) + (64'(prod_s1[r][1]) >>> F)
				+ (64'(prod_s1[r][2]) >>> F) + 64'(trans_s1[r]);
			cl[r] = tsp_pkg::clamp_sat(acc[r], W);
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			pqr[r] <= cl[r][W-1:0];
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/tsp_isqrt.sv
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module tsp_isqrt #(
	parameter int unsigned ROOT_W = 64,
	parameter int unsigned SIDE_W = 64
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  vld_i,
	input  wire logic [2*ROOT_W-1:0]   rad,
	input  wire logic [SIDE_W-1:0]     side_i,
	output logic                       vld_o,
	output logic [ROOT_W-1:0]          root,
	output logic [SIDE_W-1:0]          side_o
);

	localparam int unsigned RMW = ROOT_W + 2;

	logic                vld_s  [ROOT_W];
	logic [RMW-1:0]      rem_s  [ROOT_W];
	logic [ROOT_W-1:0]   root_s [ROOT_W];
	logic [2*ROOT_W-1:0] rad_s  [ROOT_W];
	logic [SIDE_W-1:0]   side_s [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
		logic                vld_in;
		logic [RMW-1:0]      rem_in;
		logic [ROOT_W-1:0]   root_in;
		logic [2*ROOT_W-1:0] rad_in;
		logic [SIDE_W-1:0]   side_in;
		logic [RMW+1:0]      cur;
		logic [RMW+1:0]      trial;
		logic [RMW+1:0]      diff;
		logic                ge;

		if (k == 0) begin : g_first
			assign vld_in  = vld_i;
			assign rem_in  = '0;
			assign root_in = '0;
			assign rad_in  = rad;
			assign side_in = side_i;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign rad_in  = rad_s[k-1];
			assign side_in = side_s[k-1];
		end

		// Bring down the next two radicand bits and try appending a one.
		assign cur   = {rem_in, rad_in[2*ROOT_W-1 -: 2]};
		assign trial = (RMW+2)'({root_in, 2'b01});
		assign ge    = cur >= trial;
		assign diff  = cur - trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? diff[RMW-1:0] : cur[RMW-1:0];
			root_s[k] <= {root_in[ROOT_W-2:0], ge};
			rad_s[k]  <= rad_in << 2;
			side_s[k] <= side_in;
		end
	end

	assign vld_o  = vld_s[ROOT_W-1];
	assign root   = root_s[ROOT_W-1];
	assign side_o = side_s[ROOT_W-1];

endmodule
`default_nettype wire

// File: hw/rtl/tsp_div.sv
// Pipelined saturating restoring divider: (root << (F+1)) / den, one quotient bit per stage.
`default_nettype none
module tsp_div #(
	parameter int unsigned VALUE_WIDTH = 32,
	parameter int unsigned FRAC_BITS   = 16
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       vld_i,
	input  wire logic [2*VALUE_WIDTH-1:0]   root,
	input  wire logic [2*VALUE_WIDTH-2:0]   den,
	input  wire logic                       front,
	output logic                            vld_o,
	output logic [VALUE_WIDTH-1:0]          term,
	output logic                            sat
);

	localparam int unsigned W  = VALUE_WIDTH;
	localparam int unsigned F  = FRAC_BITS;
	localparam int unsigned NW = 2*W + F + 1;
	localparam int unsigned DW = 2*W - 1;
	localparam int unsigned RW = (NW > DW + W) ? NW : DW + W;

	logic          vld_s   [W+1];
	logic [RW-1:0] rem_s   [W+1];
	logic [DW-1:0] den_s   [W+1];
	logic          front_s [W+1];
	logic          sat_s   [W+1];
	logic [W-1:0]  quo_s   [W+1];

	logic [RW-1:0] num;
	logic [RW-1:0] den_top;

	assign num     = RW'(root) << (F + 1);
	assign den_top = RW'(den) << W;

	// The quotient overflows the output range exactly when num >= den * 2^W.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else begin
			vld_s[0] <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]   <= num;
		den_s[0]   <= den;
		front_s[0] <= front;
		sat_s[0]   <= front && (num >= den_top);
		quo_s[0]   <= '0;
	end

	for (genvar j = 1; j <= W; j++) begin : g_stage
		logic [RW-1:0] dsh;
		logic          ge;

		assign dsh = RW'(den_s[j-1]) << (W - j);
		assign ge  = rem_s[j-1] >= dsh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else begin
				vld_s[j] <= vld_s[j-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[j]   <= ge ? rem_s[j-1] - dsh : rem_s[j-1];
			den_s[j]   <= den_s[j-1];
			front_s[j] <= front_s[j-1];
			sat_s[j]   <= sat_s[j-1];
			quo_s[j]   <= {quo_s[j-1][W-2:0], ge};
		end
	end

	assign vld_o = vld_s[W];
	assign sat   = sat_s[W];
	assign term  = !front_s[W] ? '0 : (sat_s[W] ? '1 : quo_s[W]);

endmodule
`default_nettype wire

// File: hw/rtl/tsp_lane.sv
// Error bound of one vertex: cross products, squared length, root and division.
`default_nettype none
module tsp_lane #(
	parameter int unsigned VALUE_WIDTH = 32,
	parameter int unsigned FRAC_BITS   = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          vld_i,
	input  wire logic signed [VALUE_WIDTH-1:0] a,
	input  wire logic signed [VALUE_WIDTH-1:0] b,
	input  wire logic signed [VALUE_WIDTH-1:0] c,
	input  wire logic signed [VALUE_WIDTH-1:0] p,
	input  wire logic signed [VALUE_WIDTH-1:0] q,
	input  wire logic signed [VALUE_WIDTH-1:0] r,
	output logic                               vld_o,
	output logic [VALUE_WIDTH-1:0]             term,
	output logic                               sat
);

	localparam int unsigned W = VALUE_WIDTH;

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;

	logic signed [2*W-1:0] ar_s1, cp_s1, br_s1, cq_s1, rr_s1, cc_s1;
	logic [2*W-1:0]        mu_s2, mv_s2;
	logic [2*W-2:0]        den_s2, den_s3, den_s4, den_s5;
	logic                  front_s2, front_s3, front_s4, front_s5;
	logic [2*W-1:0]        uhh_s3, uhl_s3, ull_s3, vhh_s3, vhl_s3, vll_s3;
	logic [4*W-1:0]        u2_s4, v2_s4;
	logic [4*W-1:0]        rad_s5;

	logic signed [2*W:0]   u_w, v_w;
	logic [2*W:0]          u_abs, v_abs;
	logic signed [2*W-1:0] den_w;

	logic                  sq_vld;
	logic [2*W-1:0]        sq_root;
	logic [2*W-1:0]        sq_side;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= vld_i;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		ar_s1 <= a * r;
		cp_s1 <= c * p;
		br_s1 <= b * r;
		cq_s1 <= c * q;
		rr_s1 <= r * r;
		cc_s1 <= c * c;
	end

	assign u_w   = $signed({ar_s1[2*W-1], ar_s1}) - $signed({cp_s1[2*W-1], cp_s1});
	assign v_w   = $signed({br_s1[2*W-1], br_s1}) - $signed({cq_s1[2*W-1], cq_s1});
	assign u_abs = u_w[2*W] ? -u_w : u_w;
	assign v_abs = v_w[2*W] ? -v_w : v_w;
	assign den_w = rr_s1 - cc_s1;

	always_ff @(posedge clk) begin
		mu_s2    <= u_abs[2*W-1:0];
		mv_s2    <= v_abs[2*W-1:0];
		den_s2   <= den_w[2*W-2:0];
		front_s2 <= rr_s1 > cc_s1;
	end

	// Squares of the 2W-bit magnitudes are built from W by W partial products.
	always_ff @(posedge clk) begin
		uhh_s3   <= mu_s2[2*W-1:W] * mu_s2[2*W-1:W];
		uhl_s3   <= mu_s2[2*W-1:W] * mu_s2[W-1:0];
		ull_s3   <= mu_s2[W-1:0] * mu_s2[W-1:0];
		vhh_s3   <= mv_s2[2*W-1:W] * mv_s2[2*W-1:W];
		vhl_s3   <= mv_s2[2*W-1:W] * mv_s2[W-1:0];
		vll_s3   <= mv_s2[W-1:0] * mv_s2[W-1:0];
		den_s3   <= den_s2;
		front_s3 <= front_s2;
	end

	always_ff @(posedge clk) begin
		u2_s4    <= {uhh_s3, ull_s3} + ((4*W)'(uhl_s3) << (W + 1));
		v2_s4    <= {vhh_s3, vll_s3} + ((4*W)'(vhl_s3) << (W + 1));
		den_s4   <= den_s3;
		front_s4 <= front_s3;
	end

	always_ff @(posedge clk) begin
		rad_s5   <= u2_s4 + v2_s4;
		den_s5   <= den_s4;
		front_s5 <= front_s4;
	end

	tsp_isqrt #(
		.ROOT_W (2*W),
		.SIDE_W (2*W)
	) u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_i  (vld_s5),
		.rad    (rad_s5),
		.side_i ({front_s5, den_s5}),
		.vld_o  (sq_vld),
		.root   (sq_root),
		.side_o (sq_side)
	);

	tsp_div #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.vld_i  (sq_vld),
		.root   (sq_root),
		.den    (sq_side[2*W-2:0]),
		.front  (sq_side[2*W-1]),
		.vld_o  (vld_o),
		.term   (term),
		.sat    (sat)
	);

endmodule
`default_nettype wire

// File: hw/rtl/terrain_split_priority_core.sv
// Top level of the terrain split priority core: matrix registers, transform and lanes.
//
//  channel   ports                                         beat taken when
//  config    cfg_we, cfg_addr, cfg_data                    cfg_we high
//  input     start, busy, wedgie, apex/right/left x,h,z    start high, busy low
//  result    done, split_priority, saturated               done high (one cycle)
//
// One triangle enters per clock; busy stays low since the datapath never stalls.
// Each vertex lane holds a square root of 2*VALUE_WIDTH stages and a divider of VALUE_WIDTH+1 stages.
// Reset clears the matrix registers and every valid bit; data registers are not reset.
// The result is presented for exactly one cycle with done high.
`default_nettype none
module terrain_split_priority_core #(
	parameter int unsigned VALUE_WIDTH = 32,
	parameter int unsigned FRAC_BITS   = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire tsp_pkg::reg_addr_t                cfg_addr,
	input  wire logic [tsp_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic [tsp_pkg::WEDGIE_W-1:0]      wedgie,
	input  wire logic [tsp_pkg::COORD_W-1:0]       apex_x,
	input  wire logic [tsp_pkg::COORD_W-1:0]       apex_h,
	input  wire logic [tsp_pkg::COORD_W-1:0]       apex_z,
	input  wire logic [tsp_pkg::COORD_W-1:0]       right_x,
	input  wire logic [tsp_pkg::COORD_W-1:0]       right_h,
	input  wire logic [tsp_pkg::COORD_W-1:0]       right_z,
	input  wire logic [tsp_pkg::COORD_W-1:0]       left_x,
	input  wire logic [tsp_pkg::COORD_W-1:0]       left_h,
	input  wire logic [tsp_pkg::COORD_W-1:0]       left_z,
	output logic                                   done,
	output logic [tsp_pkg::COORD_W-1:0]            split_priority,
	output logic                                   saturated
);

	localparam int unsigned W  = VALUE_WIDTH;
	localparam int unsigned F  = FRAC_BITS;
	localparam int unsigned HW = tsp_pkg::HALF_W;
	localparam logic [tsp_pkg::WEDGIE_W-1:0] WMAX =
		tsp_pkg::WEDGIE_W'((64'd1 << (W - 1)) - 64'd1);

	logic signed [W-1:0] m0_q, m1_q, m2_q, m4_q, m5_q, m6_q;
	logic signed [W-1:0] m8_q, m9_q, m10_q, m12_q, m13_q, m14_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m0_q  <= '0;
			m1_q  <= '0;
			m2_q  <= '0;
			m4_q  <= '0;
			m5_q  <= '0;
			m6_q  <= '0;
			m8_q  <= '0;
			m9_q  <= '0;
			m10_q <= '0;
			m12_q <= '0;
			m13_q <= '0;
			m14_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				tsp_pkg::REG_MAT_E0_E1: begin
					m0_q <= cfg_data[W-1:0];
					m1_q <= cfg_data[HW+W-1:HW];
				end
				tsp_pkg::REG_MAT_E2_E4: begin
					m2_q <= cfg_data[W-1:0];
					m4_q <= cfg_data[HW+W-1:HW];
				end
				tsp_pkg::REG_MAT_E5_E6: begin
					m5_q <= cfg_data[W-1:0];
					m6_q <= cfg_data[HW+W-1:HW];
				end
				tsp_pkg::REG_MAT_E8_E9: begin
					m8_q <= cfg_data[W-1:0];
					m9_q <= cfg_data[HW+W-1:HW];
				end
				tsp_pkg::REG_MAT_E10_E12: begin
					m10_q <= cfg_data[W-1:0];
					m12_q <= cfg_data[HW+W-1:HW];
				end
				tsp_pkg::REG_MAT_E13_E14: begin
					m13_q <= cfg_data[W-1:0];
					m14_q <= cfg_data[HW+W-1:HW];
				end
				default: begin
				end
			endcase
		end
	end

	assign busy = 1'b0;

	logic signed [W-1:0] coef [3][4];

	assign coef[0][0] = m0_q;
	assign coef[0][1] = m4_q;
	assign coef[0][2] = m8_q;
	assign coef[0][3] = m12_q;
	assign coef[1][0] = m1_q;
	assign coef[1][1] = m5_q;
	assign coef[1][2] = m9_q;
	assign coef[1][3] = m13_q;
	assign coef[2][0] = m2_q;
	assign coef[2][1] = m6_q;
	assign coef[2][2] = m10_q;
	assign coef[2][3] = m14_q;

	logic signed [W-1:0] vtx [3][3];

	assign vtx[0][0] = apex_x[W-1:0];
	assign vtx[0][1] = apex_h[W-1:0];
	assign vtx[0][2] = apex_z[W-1:0];
	assign vtx[1][0] = right_x[W-1:0];
	assign vtx[1][1] = right_h[W-1:0];
	assign vtx[1][2] = right_z[W-1:0];
	assign vtx[2][0] = left_x[W-1:0];
	assign vtx[2][1] = left_h[W-1:0];
	assign vtx[2][2] = left_z[W-1:0];

	// Wedgie thickness is clamped to the positive signed range first.
	logic [tsp_pkg::WEDGIE_W-1:0] w_sat;
	logic [31:0]                  w_ext;
	logic signed [W-1:0]          w_v;

	assign w_sat = (wedgie > WMAX) ? WMAX : wedgie;
	assign w_ext = {1'b0, w_sat};
	assign w_v   = w_ext[W-1:0];

	logic                  vld_s1, vld_s2;
	logic signed [2*W-1:0] wa_s1, wb_s1, wc_s1;
	logic signed [W-1:0]   a_s2, b_s2, c_s2;
	logic [31:0]           a_cl, b_cl, c_cl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		wa_s1 <= m4_q * w_v;
		wb_s1 <= m5_q * w_v;
		wc_s1 <= m6_q * w_v;
	end

	assign a_cl = tsp_pkg::clamp_sat(64'(wa_s1) >>> F, W);
	assign b_cl = tsp_pkg::clamp_sat(64'(wb_s1) >>> F, W);
	assign c_cl = tsp_pkg::clamp_sat(64'(wc_s1) >>> F, W);

	always_ff @(posedge clk) begin
		a_s2 <= a_cl[W-1:0];
		b_s2 <= b_cl[W-1:0];
		c_s2 <= c_cl[W-1:0];
	end

	logic signed [W-1:0] pqr [3][3];
	logic                lane_vld [3];
	logic [W-1:0]        lane_term [3];
	logic                lane_sat [3];

	for (genvar k = 0; k < 3; k++) begin : g_vertex
		tsp_xform #(
			.VALUE_WIDTH (VALUE_WIDTH),
			.FRAC_BITS   (FRAC_BITS)
		) u_xform (
			.clk  (clk),
			.coef (coef),
			.crd  (vtx[k]),
			.pqr  (pqr[k])
		);

		tsp_lane #(
			.VALUE_WIDTH (VALUE_WIDTH),
			.FRAC_BITS   (FRAC_BITS)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_i  (vld_s2),
			.a      (a_s2),
			.b      (b_s2),
			.c      (c_s2),
			.p      (pqr[k][0]),
			.q      (pqr[k][1]),
			.r      (pqr[k][2]),
			.vld_o  (lane_vld[k]),
			.term   (lane_term[k]),
			.sat    (lane_sat[k])
		);
	end

	logic [W-1:0] best01, best;
	logic         done_q, sat_q;
	logic [W-1:0] prio_q;

	assign best01 = (lane_term[1] > lane_term[0]) ? lane_term[1] : lane_term[0];
	assign best   = (lane_term[2] > best01) ? lane_term[2] : best01;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= lane_vld[0] && lane_vld[1] && lane_vld[2];
		end
	end

	always_ff @(posedge clk) begin
		prio_q <= best;
		sat_q  <= lane_sat[0] || lane_sat[1] || lane_sat[2];
	end

	assign done           = done_q;
	assign split_priority = tsp_pkg::COORD_W'(prio_q);
	assign saturated      = sat_q;

endmodule
`default_nettype wire
